/* hdl/pfbs_pkg.sv */
// Shared constants and types for the PPP frame byte stuffer.
package pfbs_pkg;

    localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
    localparam logic [7:0]  ESC_BYTE       = 8'h7D;
    localparam logic [7:0]  FCS_FILL       = 8'h00;
    localparam logic [7:0]  ADDRESS_RESET  = 8'hFF;
    localparam logic [7:0]  CONTROL_RESET  = 8'hC0;
    localparam logic [15:0] PROTOCOL_RESET = 16'h0021;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_ADDRESS  = 2'd0,
        REG_CONTROL  = 2'd1,
        REG_PROTOCOL = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       frame_end;
        logic       escape;
    } item_desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic [7:0]  address_byte;
        logic [7:0]  control_byte;
        logic [15:0] protocol_word;
    } frame_cfg_t;

endpackage

/* hdl/pfbs_stream_if.sv */
// Stream channel interfaces: payload bytes in, framed bytes out.
interface pfbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;

    modport source (output valid, data_byte, frame_start, frame_end, input ready);
    modport sink   (input valid, data_byte, frame_start, frame_end, output ready);
endinterface

interface pfbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_byte, out_last, input ready);
    modport sink   (input valid, out_byte, out_last, output ready);
endinterface

/* hdl/pfbs_queue.sv */
// Small descriptor queue between the front classifier and the back sequencer.
module pfbs_queue #(
    parameter int DEPTH = pfbs_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pfbs_pkg::item_desc_t push_item,
    input  logic                 pop,
    output pfbs_pkg::item_desc_t head,
    output pfbs_pkg::queue_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfbs_pkg::item_desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end
        else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_advance(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

/* hdl/pfbs_front.sv */
// Front end: accept payload bytes and classify them for the sequencer.
module pfbs_front (
    pfbs_in_if.sink                payload,
    input  pfbs_pkg::queue_stat_t  stat,
    output logic                   push,
    output pfbs_pkg::item_desc_t   push_item
);

    assign payload.ready = !stat.full;
    assign push          = payload.valid && !stat.full;

    always_comb
    begin
        push_item.data_byte   = payload.data_byte;
        push_item.frame_start = payload.frame_start;
        push_item.frame_end   = payload.frame_end;
        // flag and escape values in the payload need an escape in front
        push_item.escape      = (payload.data_byte == pfbs_pkg::FLAG_BYTE) ||
                                (payload.data_byte == pfbs_pkg::ESC_BYTE);
    end

endmodule

/* hdl/pfbs_back.sv */
// Back end: walk the header, escape, data and trailer steps of each item.
module pfbs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfbs_pkg::item_desc_t  head,
    input  pfbs_pkg::queue_stat_t stat,
    input  pfbs_pkg::frame_cfg_t  cfg,
    output logic                  pop,
    pfbs_out_if.source            framed
);

    typedef enum logic [3:0] {
        ST_FLAG_OPEN,
        ST_ADDR,
        ST_CTRL,
        ST_PROTO_HI,
        ST_PROTO_LO,
        ST_ESC,
        ST_DATA,
        ST_FCS_HI,
        ST_FCS_LO,
        ST_FLAG_CLOSE
    } step_t;

    step_t      step_reg, step_next;
    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    step_t      cur_step;
    step_t      succ_step;
    logic [7:0] cur_byte;
    logic       item_done;
    logic       emit;

    always_comb
    begin
        if (busy_reg) begin
            cur_step = step_reg;
        end
        else if (head.frame_start) begin
            cur_step = ST_FLAG_OPEN;
        end
        else if (head.escape) begin
            cur_step = ST_ESC;
        end
        else begin
            cur_step = ST_DATA;
        end

        cur_byte  = pfbs_pkg::FLAG_BYTE;
        succ_step = ST_DATA;
        item_done = 1'b0;
        case (cur_step)
            ST_FLAG_OPEN:
            begin
                cur_byte  = pfbs_pkg::FLAG_BYTE;
                succ_step = ST_ADDR;
            end
            ST_ADDR:
            begin
                cur_byte  = cfg.address_byte;
                succ_step = ST_CTRL;
            end
            ST_CTRL:
            begin
                cur_byte  = cfg.control_byte;
                succ_step = ST_PROTO_HI;
            end
            ST_PROTO_HI:
            begin
                cur_byte  = cfg.protocol_word[15:8];
                succ_step = ST_PROTO_LO;
            end
            ST_PROTO_LO:
            begin
                cur_byte  = cfg.protocol_word[7:0];
                succ_step = head.escape ? ST_ESC : ST_DATA;
            end
            ST_ESC:
            begin
                cur_byte  = pfbs_pkg::ESC_BYTE;
                succ_step = ST_DATA;
            end
            ST_DATA:
            begin
                cur_byte  = head.data_byte;
                succ_step = ST_FCS_HI;
                item_done = !head.frame_end;
            end
            ST_FCS_HI:
            begin
                cur_byte  = pfbs_pkg::FCS_FILL;
                succ_step = ST_FCS_LO;
            end
            ST_FCS_LO:
            begin
                cur_byte  = pfbs_pkg::FCS_FILL;
                succ_step = ST_FLAG_CLOSE;
            end
            ST_FLAG_CLOSE:
            begin
                cur_byte  = pfbs_pkg::FLAG_BYTE;
                item_done = 1'b1;
            end
            default:
            begin
                cur_byte  = pfbs_pkg::FLAG_BYTE;
                item_done = 1'b1;
            end
        endcase

        emit = !stat.empty && (!out_valid_reg || framed.ready);
        pop  = emit && item_done;

        step_next      = step_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            step_next      = succ_step;
            busy_next      = !item_done;
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            out_last_next  = item_done;
        end
        else if (framed.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= ST_FLAG_OPEN;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else begin
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign framed.valid    = out_valid_reg;
    assign framed.out_byte = out_byte_reg;
    assign framed.out_last = out_last_reg;

endmodule

/* hdl/ppp_frame_byte_stuffer_core.sv */
// Top level of the PPP frame byte stuffer: APB registers, front, queue and back.
//
// Takes one payload byte per transaction and sends the framed, byte-stuffed
// stream one byte per transaction. A byte flagged frame_start is preceded by
// the opening flag 0x7E, the address byte, the control byte and the protocol
// word (high byte first); a payload byte equal to 0x7E or 0x7D is preceded
// by the escape 0x7D and is sent unchanged; a byte flagged frame_end is
// followed by two zero FCS bytes and the closing flag 0x7E. out_last marks
// the final output byte caused by each input byte. No frame state is kept:
// every input byte is framed exactly as its own flags say. An input byte
// becomes 1 + 5*frame_start + escape + 3*frame_end output bytes, from 1 to
// 10; the back sequencer emits one byte per cycle while the sink is ready,
// so plain bytes stream at one per cycle. The front classifies each byte and
// places it in a QUEUE_DEPTH-entry queue, so input can be taken while the
// output register holds a byte waiting for the sink. Registers at byte
// address 0 (address_byte, reset 0xFF), 4 (control_byte, reset 0xC0) and
// 8 (protocol_word, reset 0x0021); write them only while the block is idle.
module ppp_frame_byte_stuffer_core #(
    parameter int QUEUE_DEPTH = pfbs_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pfbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pfbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    pfbs_in_if.sink                         payload,
    pfbs_out_if.source                      framed
);

    pfbs_pkg::frame_cfg_t  cfg_reg;
    pfbs_pkg::item_desc_t  push_item;
    pfbs_pkg::item_desc_t  head;
    pfbs_pkg::queue_stat_t stat;
    logic                  push;
    logic                  pop;
    logic                  cfg_write;
    logic [1:0]            reg_sel;

    // Word index; low address bits are ignored.
    assign reg_sel   = paddr[3:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Hold the framing fields; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.address_byte  <= pfbs_pkg::ADDRESS_RESET;
            cfg_reg.control_byte  <= pfbs_pkg::CONTROL_RESET;
            cfg_reg.protocol_word <= pfbs_pkg::PROTOCOL_RESET;
        end
        else if (cfg_write) begin
            case (reg_sel)
                pfbs_pkg::REG_ADDRESS:  cfg_reg.address_byte  <= pwdata[7:0];
                pfbs_pkg::REG_CONTROL:  cfg_reg.control_byte  <= pwdata[7:0];
                pfbs_pkg::REG_PROTOCOL: cfg_reg.protocol_word <= pwdata[15:0];
                default:                cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Read back the selected register, zero-extended to the bus width.
    always_comb
    begin
        case (reg_sel)
            pfbs_pkg::REG_ADDRESS:
                prdata = pfbs_pkg::APB_DATA_W'(cfg_reg.address_byte);
            pfbs_pkg::REG_CONTROL:
                prdata = pfbs_pkg::APB_DATA_W'(cfg_reg.control_byte);
            pfbs_pkg::REG_PROTOCOL:
                prdata = pfbs_pkg::APB_DATA_W'(cfg_reg.protocol_word);
            default:
                prdata = '0;
        endcase
    end

    // Classify each accepted byte: flags plus whether it needs an escape.
    pfbs_front u_front (
        .payload   (payload),
        .stat      (stat),
        .push      (push),
        .push_item (push_item)
    );

    // Decouple acceptance from emission so either side can stall alone.
    pfbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    // Advance one output byte per cycle, while the sink is not stalling, through the steps of the head item.
    pfbs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (stat),
        .cfg    (cfg_reg),
        .pop    (pop),
        .framed (framed)
    );

endmodule

/* hdl/pfbs_checker.sv */
// Port-level checks for the PPP frame byte stuffer, bound to the top level.
module pfbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic       in_acc;
    logic       out_acc;
    logic [7:0] prev_byte_reg;
    logic       prev_last_reg;
    logic [3:0] pending_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_byte_reg <= '0;
            prev_last_reg <= 1'b1;
            pending_reg   <= '0;
        end
        else begin
            if (out_acc) begin
                prev_byte_reg <= out_byte;
                prev_last_reg <= out_last;
            end
            pending_reg <= pending_reg + {3'b000, in_acc} - {3'b000, out_acc && out_last};
        end
    end

    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_last_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && out_last |-> pending_reg != 4'd0)
        else $error("item completed with no accepted input outstanding");

    a_last_escape_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && out_last && out_byte == pfbs_pkg::ESC_BYTE |->
            prev_byte_reg == pfbs_pkg::ESC_BYTE && !prev_last_reg)
        else $error("escape value ended an item without a preceding escape");

    a_escape_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && prev_last_reg && out_byte == pfbs_pkg::ESC_BYTE |-> !out_last)
        else $error("leading escape byte marked as last of its item");

endmodule

bind ppp_frame_byte_stuffer_core pfbs_checker u_pfbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (payload.valid),
    .in_ready  (payload.ready),
    .out_valid (framed.valid),
    .out_ready (framed.ready),
    .out_byte  (framed.out_byte),
    .out_last  (framed.out_last)
);

/* dv/tb_top.sv */
// Testbench for the PPP frame byte stuffer: directed table, random frames, scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One directed row: payload byte, frame flags and, where the answer is
    // obvious, the framed bytes typed in (first byte in the highest lane).
    // byte_count of zero means the row is checked against the framing model.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        opens;
        logic        closes;
        logic [3:0]  byte_count;
        logic [79:0] framed_bytes;
    } stim_row_t;

    // One framed output byte as the sink should see it.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } framed_byte_t;

    // Receiver back-pressure patterns.
    typedef enum int unsigned {
        RX_OPEN = 0,
        RX_COIN = 1,
        RX_COMB = 2,
        RX_HOLD = 3
    } rx_mode_t;

    localparam int DIRECTED_ROWS = 14;
    localparam int RX_COMB_PERIOD = 7;
    localparam int RX_COMB_LOW    = 3;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pfbs_pkg::APB_ADDR_W-1:0] paddr;
    logic [pfbs_pkg::APB_DATA_W-1:0] pwdata;
    logic [pfbs_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    pfbs_in_if  payload_ch ();
    pfbs_out_if framed_ch ();

    ppp_frame_byte_stuffer_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .payload (payload_ch),
        .framed  (framed_ch)
    );

    // Shadow of the framing registers and the bytes still owed by the block.
    pfbs_pkg::frame_cfg_t shadow_cfg;
    framed_byte_t         framed_queue [$];
    int unsigned          mismatch_count = 0;

    // Sender burst bookkeeping; offer_up tracks what valid was last set to.
    int unsigned  burst_left = 0;
    bit           offer_up = 1'b0;

    // Receiver pattern state.
    rx_mode_t     rx_mode = RX_OPEN;
    int unsigned  rx_mode_left = 0;
    int unsigned  rx_tick = 0;
    int unsigned  rx_hold = 0;

    // Directed table: the first rows run with the reset register values, so
    // their framing can be read straight off the header and trailer layout.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // single-byte frame: header, byte, FCS filler, closing flag
        {8'h41, 1'b1, 1'b1, 4'd9,  80'h7EFFC000214100007E},
        // unflagged extremes pass straight through
        {8'h00, 1'b0, 1'b0, 4'd1,  80'h00},
        {8'hFF, 1'b0, 1'b0, 4'd1,  80'hFF},
        // flag and escape payload bytes get an escape in front, sent unchanged
        {8'h7E, 1'b0, 1'b0, 4'd2,  80'h7D7E},
        {8'h7D, 1'b0, 1'b0, 4'd2,  80'h7D7D},
        // longest case: header, escape, byte and trailer
        {8'h7E, 1'b1, 1'b1, 4'd10, 80'h7EFFC000217D7E00007E},
        {8'h55, 1'b1, 1'b0, 4'd6,  80'h7EFFC0002155},
        {8'hAA, 1'b0, 1'b0, 4'd1,  80'hAA},
        {8'h7D, 1'b0, 1'b1, 4'd5,  80'h7D7D00007E},
        // end with no start in front of it
        {8'h01, 1'b0, 1'b1, 4'd4,  80'h0100007E},
        // two starts in a row, then the rest against the model
        {8'h7C, 1'b1, 1'b0, 4'd0,  80'h0},
        {8'h7F, 1'b1, 1'b0, 4'd0,  80'h0},
        {8'h80, 1'b0, 1'b1, 4'd0,  80'h0},
        {8'h3C, 1'b0, 1'b0, 4'd0,  80'h0}
    };

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Append the bytes one payload byte turns into under the current registers.
    task automatic frame_payload(input logic [7:0] data_byte, input logic opens,
                                 input logic closes);
        framed_byte_t burst [$];
        if (opens)
        begin
            burst.push_back('{pfbs_pkg::FLAG_BYTE, 1'b0});
            burst.push_back('{shadow_cfg.address_byte, 1'b0});
            burst.push_back('{shadow_cfg.control_byte, 1'b0});
            burst.push_back('{shadow_cfg.protocol_word[15:8], 1'b0});
            burst.push_back('{shadow_cfg.protocol_word[7:0], 1'b0});
        end
        if (data_byte == pfbs_pkg::FLAG_BYTE || data_byte == pfbs_pkg::ESC_BYTE)
            burst.push_back('{pfbs_pkg::ESC_BYTE, 1'b0});
        burst.push_back('{data_byte, 1'b0});
        if (closes)
        begin
            burst.push_back('{pfbs_pkg::FCS_FILL, 1'b0});
            burst.push_back('{pfbs_pkg::FCS_FILL, 1'b0});
            burst.push_back('{pfbs_pkg::FLAG_BYTE, 1'b0});
        end
        burst[burst.size() - 1].out_last = 1'b1;
        foreach (burst[k])
            framed_queue.push_back(burst[k]);
    endtask

    // Payload byte biased toward the values that trigger escaping.
    function automatic logic [7:0] pick_payload();
        logic [7:0] pick;
        case ($urandom_range(0, 9))
            0, 1:    pick = pfbs_pkg::FLAG_BYTE;
            2:       pick = pfbs_pkg::ESC_BYTE;
            3:       pick = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: pick = 8'($urandom);
        endcase
        return pick;
    endfunction

    // Offer one payload byte and hold it until the transaction completes.
    // When predict is clear the caller has already queued the expected bytes.
    task automatic offer_byte(input logic [7:0] data_byte, input logic opens,
                              input logic closes, input bit predict);
        int unsigned gap;
        payload_ch.valid       <= 1'b1;
        payload_ch.data_byte   <= data_byte;
        payload_ch.frame_start <= opens;
        payload_ch.frame_end   <= closes;
        offer_up = 1'b1;
        do
            @(posedge clk);
        while (!payload_ch.ready);
        if (predict)
            frame_payload(data_byte, opens, closes);
        // Advance the burst; at its end drop valid for a random gap.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            payload_ch.valid <= 1'b0;
            offer_up = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Drop valid and hold until every queued framed byte has come out.
    task automatic wait_quiet();
        if (offer_up)
        begin
            payload_ch.valid <= 1'b0;
            offer_up = 1'b0;
        end
        while (framed_queue.size() != 0)
            @(posedge clk);
    endtask

    // APB write: setup phase, access phase until pready, then idle before returning.
    task automatic write_reg(input pfbs_pkg::reg_index_t idx,
                             input logic [pfbs_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pfbs_pkg::REG_ADDRESS:  shadow_cfg.address_byte  = value[7:0];
            pfbs_pkg::REG_CONTROL:  shadow_cfg.control_byte  = value[7:0];
            pfbs_pkg::REG_PROTOCOL: shadow_cfg.protocol_word = value[15:0];
            default:                ;
        endcase
        @(posedge clk);
    endtask

    // Load all three framing registers; junk in the unused upper bits
    // must be dropped by the block.
    task automatic set_framing(input logic [7:0] address_byte,
                               input logic [7:0] control_byte,
                               input logic [15:0] protocol_word);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(pfbs_pkg::REG_ADDRESS, {junk[31:8], address_byte});
        junk = $urandom;
        write_reg(pfbs_pkg::REG_CONTROL, {junk[31:8], control_byte});
        junk = $urandom;
        write_reg(pfbs_pkg::REG_PROTOCOL, {junk[31:16], protocol_word});
    endtask

    // Mostly well-formed frames of random length and content, with stray
    // bytes carrying random flags mixed in. Pause once midway until drained.
    task automatic run_frames(input int unsigned item_goal);
        int unsigned sent;
        int unsigned frame_len;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < item_goal)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                offer_byte(pick_payload(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'b1);
                sent++;
            end
            else
            begin
                frame_len = $urandom_range(1, 8);
                for (int unsigned k = 0; k < frame_len; k++)
                    offer_byte(pick_payload(), k == 0, k == frame_len - 1, 1'b1);
                sent += frame_len;
            end
            if (!paused && sent >= item_goal / 2)
            begin
                wait_quiet();
                paused = 1'b1;
            end
        end
    endtask

    // Receiver: switch at random among back-pressure patterns, holding each for a random stretch.
    initial
    begin
        framed_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 80);
            end
            rx_mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN: framed_ch.ready <= 1'b1;
                RX_COIN: framed_ch.ready <= 1'($urandom_range(0, 1));
                RX_COMB: framed_ch.ready <= (rx_tick % RX_COMB_PERIOD) >= RX_COMB_LOW;
                default:
                begin
                    if (rx_hold > 0)
                    begin
                        rx_hold--;
                        framed_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        framed_ch.ready <= 1'b1;
                        if ($urandom_range(0, 4) == 0)
                            rx_hold = $urandom_range(1, 6);
                    end
                end
            endcase
        end
    end

    // Scoreboard: compare each framed transaction with the oldest expectation.
    always @(posedge clk)
    begin
        framed_byte_t want;
        if (rst_n && framed_ch.valid && framed_ch.ready)
        begin
            if (framed_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected framed byte: expected none got %02h last %0b",
                         $time, framed_ch.out_byte, framed_ch.out_last);
            end
            else
            begin
                want = framed_queue.pop_front();
                if (framed_ch.out_byte !== want.out_byte)
                begin
                    mismatch_count++;
                    $display("%0t: out_byte mismatch: expected %02h got %02h",
                             $time, want.out_byte, framed_ch.out_byte);
                end
                if (framed_ch.out_last !== want.out_last)
                begin
                    mismatch_count++;
                    $display("%0t: out_last mismatch: expected %0b got %0b",
                             $time, want.out_last, framed_ch.out_last);
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases under several
    // register settings, extremes first.
    initial
    begin
        framed_byte_t typed;
        int unsigned  n;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        payload_ch.valid       = 1'b0;
        payload_ch.data_byte   = 8'h00;
        payload_ch.frame_start = 1'b0;
        payload_ch.frame_end   = 1'b0;
        shadow_cfg = '{pfbs_pkg::ADDRESS_RESET, pfbs_pkg::CONTROL_RESET,
                       pfbs_pkg::PROTOCOL_RESET};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with the reset register values.
        foreach (directed_rows[r])
        begin
            n = directed_rows[r].byte_count;
            for (int unsigned k = 0; k < n; k++)
            begin
                typed.out_byte = directed_rows[r].framed_bytes[8 * (n - 1 - k) +: 8];
                typed.out_last = (k == n - 1);
                framed_queue.push_back(typed);
            end
            offer_byte(directed_rows[r].data_byte, directed_rows[r].opens,
                       directed_rows[r].closes, n == 0);
        end
        wait_quiet();

        // All-zero and all-one registers.
        set_framing(8'h00, 8'h00, 16'h0000);
        run_frames(50);
        wait_quiet();

        set_framing(8'hFF, 8'hFF, 16'hFFFF);
        run_frames(50);
        wait_quiet();

        // Header fields that look like flag and escape must not be escaped.
        set_framing(pfbs_pkg::FLAG_BYTE, pfbs_pkg::ESC_BYTE,
                    {pfbs_pkg::FLAG_BYTE, pfbs_pkg::ESC_BYTE});
        run_frames(50);
        wait_quiet();

        repeat (2)
        begin
            set_framing(8'($urandom), 8'($urandom), 16'($urandom));
            run_frames(55);
            wait_quiet();
        end

        // Let any stray trailing transaction show up before judging.
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && framed_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
